[src/complex_nco_mixer_assert.svh]
// Assertion macros for the complex NCO mixer checker.
`ifndef COMPLEX_NCO_MIXER_ASSERT_SVH
`define COMPLEX_NCO_MIXER_ASSERT_SVH

// Checked at every rising edge of clk, off while rst is high.
`define CNM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define CNM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cnm_pkg.sv]
// Shared types, constants and the sine table builder of the complex NCO mixer.
package cnm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_BITS_DEF = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int AMP_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FREQ_WORD,
    REG_START_PHASE,
    REG_GEN_MODE
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_re;
    logic signed [SAMPLE_BITS-1:0] in_im;
  } in_sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
  } out_sample_t;

  // Floor quotient by shift and subtract, one quotient bit per step.
  function automatic longint unsigned udiv_floor(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry r of a table with 2^tab_bits entries per turn.
  // Evaluated at elaboration only, to fill the constant table.
  function automatic longint unsigned quarter_sine(longint unsigned r, int tab_bits,
                                                   int sample_bits);
    longint unsigned x;
    longint unsigned t;
    longint unsigned amp;
    longint unsigned v;
    longint sum;
    longint unsigned div;
    bit neg;
    x = (r * 64'd2 * PI_Q30 + (64'd1 << (tab_bits - 1))) >> tab_bits;
    t = x;
    sum = longint'(x);
    amp = (64'd1 << (sample_bits - 1)) - 64'd1;
    neg = 1'b1;
    for (int n = 3; n <= 17; n += 2) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      div = 64'(n * (n - 1));
      t = udiv_floor(t, div);
      if (neg) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
      neg = !neg;
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return v;
  endfunction

  // Saturate a rounded mixer sum to the signed sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      logic signed [2*SAMPLE_BITS:0] v);
    logic signed [2*SAMPLE_BITS:0] hi;
    logic signed [2*SAMPLE_BITS:0] lo;
    hi = (2*SAMPLE_BITS+1)'(AMP_MAX);
    lo = (2*SAMPLE_BITS+1)'(-AMP_MAX - 1);
    if (v > hi) begin
      return SAMPLE_BITS'(hi);
    end else if (v < lo) begin
      return SAMPLE_BITS'(lo);
    end
    return SAMPLE_BITS'(v);
  endfunction

endpackage

[src/complex_nco_mixer.sv]
// Top level of the complex NCO mixer: phase accumulator, sine lookup and complex mixer.
//
//   channel  direction  handshake         payload
//   in       into block in_valid/in_stall  in_data  (in_re, in_im)
//   out      from block out_valid/out_stall out_data (out_re, out_im)
//   cfg      into block cfg_valid/cfg_ready cfg_index, cfg_data
//
// One sample per clock while the output is not stalled; a sample passes the input register,
// the registered sine table read, the product register and the output register in turn.
// Reset clears the phase and frequency, selects mix mode and empties the pipeline.
// Each stage holds while the next one is full and held; empty stages still take
// new samples, so in_stall rises only when every stage is full and out_stall is high.
module complex_nco_mixer #(
  parameter int PHASE_BITS      = cnm_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = cnm_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cnm_pkg::in_sample_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cnm_pkg::out_sample_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cnm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cnm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import cnm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int TB = TABLE_ADDR_BITS;
  localparam int IdxBits = TB - 1;
  localparam logic [IdxBits-1:0] Quarter = IdxBits'(2 ** (TB - 2));
  localparam logic signed [2*SB:0] RoundHalf = (2*SB+1)'(2 ** (SB - 2));

  // Configuration and phase state.
  logic [CFG_DATA_BITS-1:0] freq_word;
  logic                     gen_mode;
  logic [PHASE_BITS-1:0]    phase_acc;

  logic [CFG_DATA_BITS+PHASE_BITS-1:0] freq_wide;
  logic [CFG_DATA_BITS+PHASE_BITS-1:0] start_wide;
  logic [PHASE_BITS-1:0]               freq_inc;
  logic [PHASE_BITS-1:0]               start_aligned;
  logic [PHASE_BITS-1:0]               phase_next;
  logic [TB-1:0]                       addr;
  logic [1:0]                          sin_quad;
  logic [1:0]                          cos_quad;
  logic [TB-3:0]                       addr_low;
  logic [IdxBits-1:0]                  sin_idx;
  logic [IdxBits-1:0]                  cos_idx;
  logic                                in_take;
  logic                                bypass;

  // Handshake chain.
  logic rdy1, rdy2, rdy3, rdy_o;

  // Stage 1: input register with folded table addresses.
  logic                    v1;
  logic signed [SB-1:0]    re1, im1;
  logic                    pass1, mode1, sneg1, cneg1;
  logic [IdxBits-1:0]      sidx1, cidx1;

  // Stage 2: table magnitudes.
  logic                    v2;
  logic signed [SB-1:0]    re2, im2;
  logic                    pass2, mode2, sneg2, cneg2;
  logic [SB-2:0]           smag2, cmag2;

  // Stage 3: products.
  logic                    v3;
  logic signed [SB-1:0]    re3, im3, c3, s3;
  logic                    pass3, mode3;
  logic signed [2*SB-1:0]  p_rc3, p_is3, p_rs3, p_ic3;

  logic signed [SB-1:0]    c_val, s_val;
  logic signed [2*SB:0]    acc_re, acc_im, rnd_re, rnd_im;
  out_sample_t             out_next;

  assign cfg_ready = 1'b1;

  // Align a 32-bit register value to the accumulator: append PHASE_BITS zeros to the value
  // and keep the top PHASE_BITS bits of the result.
  assign freq_wide     = {freq_word, {PHASE_BITS{1'b0}}};
  assign start_wide    = {cfg_data, {PHASE_BITS{1'b0}}};
  assign freq_inc      = freq_wide[CFG_DATA_BITS+PHASE_BITS-1 -: PHASE_BITS];
  assign start_aligned = start_wide[CFG_DATA_BITS+PHASE_BITS-1 -: PHASE_BITS];

  assign bypass     = (freq_word == '0);
  assign phase_next = phase_acc + freq_inc;
  assign addr       = phase_next[PHASE_BITS-1 -: TB];
  assign sin_quad   = addr[TB-1 -: 2];
  assign cos_quad   = sin_quad + 2'd1;
  assign addr_low   = addr[TB-3:0];
  assign sin_idx    = sin_quad[0] ? Quarter - {1'b0, addr_low} : {1'b0, addr_low};
  assign cos_idx    = cos_quad[0] ? Quarter - {1'b0, addr_low} : {1'b0, addr_low};

  assign rdy_o    = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy_o;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign in_take  = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_word <= '0;
      gen_mode  <= 1'b1;
      phase_acc <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FREQ_WORD:   freq_word <= cfg_data;
          REG_START_PHASE: phase_acc <= start_aligned;
          REG_GEN_MODE:    gen_mode  <= cfg_data[0];
          default: ;
        endcase
      end else if (in_take && !bypass) begin
        phase_acc <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      re1   <= in_data.in_re;
      im1   <= in_data.in_im;
      pass1 <= bypass;
      mode1 <= gen_mode;
      sidx1 <= sin_idx;
      sneg1 <= sin_quad[1];
      cidx1 <= cos_idx;
      cneg1 <= cos_quad[1];
    end
  end

  cnm_sine_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (rdy2),
    .addr_a (sidx1),
    .addr_b (cidx1),
    .data_a (smag2),
    .data_b (cmag2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      re2   <= re1;
      im2   <= im1;
      pass2 <= pass1;
      mode2 <= mode1;
      sneg2 <= sneg1;
      cneg2 <= cneg1;
    end
  end

  always_comb begin
    s_val = sneg2 ? -$signed({1'b0, smag2}) : $signed({1'b0, smag2});
    c_val = cneg2 ? -$signed({1'b0, cmag2}) : $signed({1'b0, cmag2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      re3   <= re2;
      im3   <= im2;
      c3    <= c_val;
      s3    <= s_val;
      pass3 <= pass2;
      mode3 <= mode2;
      p_rc3 <= re2 * c_val;
      p_is3 <= im2 * s_val;
      p_rs3 <= re2 * s_val;
      p_ic3 <= im2 * c_val;
    end
  end

  // Round half up at the Q1.(SB-1) point; the arithmetic shift floors.
  always_comb begin
    acc_re = (2*SB+1)'(p_rc3) - (2*SB+1)'(p_is3);
    acc_im = (2*SB+1)'(p_rs3) + (2*SB+1)'(p_ic3);
    rnd_re = (acc_re + RoundHalf) >>> (SB - 1);
    rnd_im = (acc_im + RoundHalf) >>> (SB - 1);
    if (pass3) begin
      out_next.out_re = re3;
      out_next.out_im = im3;
    end else if (!mode3) begin
      out_next.out_re = c3;
      out_next.out_im = s3;
    end else begin
      out_next.out_re = sat_sample(rnd_re);
      out_next.out_im = sat_sample(rnd_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= v3;
    end
    if (rdy_o) begin
      out_data <= out_next;
    end
  end

endmodule

[src/cnm_sine_rom.sv]
// Quarter-wave sine table with two registered read ports.
module cnm_sine_rom #(
  parameter int TABLE_ADDR_BITS = cnm_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [TABLE_ADDR_BITS-2:0]        addr_a,
  input  logic [TABLE_ADDR_BITS-2:0]        addr_b,
  output logic [cnm_pkg::SAMPLE_BITS-2:0]   data_a,
  output logic [cnm_pkg::SAMPLE_BITS-2:0]   data_b
);
  import cnm_pkg::*;

  localparam int Depth = 2 ** (TABLE_ADDR_BITS - 2) + 1;

  logic [SAMPLE_BITS-2:0] qtab [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam logic [SAMPLE_BITS-2:0] Val =
      (SAMPLE_BITS-1)'(quarter_sine(64'(k), TABLE_ADDR_BITS, SAMPLE_BITS));
    assign qtab[k] = Val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= qtab[addr_a];
      data_b <= qtab[addr_b];
    end
  end

endmodule

[src/complex_nco_mixer_checker.sv]
// Port-level checker for the complex NCO mixer and its bind to the top level.
`include "complex_nco_mixer_assert.svh"

module complex_nco_mixer_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input cnm_pkg::out_sample_t out_data
);
  import cnm_pkg::*;

  // The pipeline is empty right after reset.
  `CNM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "out_valid high after reset")

  // The input side only holds off when the whole pipeline is backed up.
  `CNM_ASSERT(a_stall_backed, in_stall |-> out_valid && out_stall, "in_stall without full pipeline")

  // A held result request keeps its value.
  `CNM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "output request changed while stalled")

endmodule

bind complex_nco_mixer complex_nco_mixer_checker u_checker (.*);

[test/tb_top.sv]
// Self-checking testbench of the complex NCO mixer: directed vectors, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnm_pkg::*;

  localparam int PH_BITS = PHASE_BITS_DEF;
  localparam int TAB_BITS = TABLE_ADDR_BITS_DEF;
  localparam int LUT_SIZE = 1 << TAB_BITS;
  localparam int QUARTER = LUT_SIZE / 4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_ITEMS = 1450;
  localparam int SEG_LEN = 50;
  localparam int NUM_DIRECTED = 21;

  typedef struct packed {
    bit                            cfg;
    logic [CFG_DATA_BITS-1:0]      freq;
    logic [CFG_DATA_BITS-1:0]      start;
    logic [CFG_DATA_BITS-1:0]      mode_word;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    bit                            known;
    logic signed [SAMPLE_BITS-1:0] exp_re;
    logic signed [SAMPLE_BITS-1:0] exp_im;
  } vector_t;

  // A zero frequency word passes the sample through in either mode, so those rows are typed in.
  vector_t directed_vectors [NUM_DIRECTED] = '{
    '{0, 0, 0, 0, 32767, -32768, 1, 32767, -32768},
    '{0, 0, 0, 0, -32768, 32767, 1, -32768, 32767},
    '{0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 0, -1, 1, 1, -1, 1},
    '{1, 32'h0000_0000, 32'h1234_5678, 32'h0000_0000, 4660, -4660, 1, 4660, -4660},
    '{1, 32'h4000_0000, 32'hC000_0000, 32'hFFFF_FFFE, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 32767, 32767, 0, 0, 0},
    '{0, 0, 0, 0, -32768, -32768, 0, 0, 0},
    '{0, 0, 0, 0, 1, -1, 0, 0, 0},
    '{1, 32'h2000_0000, 32'h0000_0000, 32'h0000_0001, 32767, -32768, 0, 0, 0},
    '{0, 0, 0, 0, -32768, -32768, 0, 0, 0},
    '{0, 0, 0, 0, 32767, 32767, 0, 0, 0},
    '{0, 0, 0, 0, -32768, 32767, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32767, 0, 0, 0, 0},
    '{0, 0, 0, 0, -32768, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, -32768, 0, 0, 0},
    '{1, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, -32768, -32768, 0, 0, 0},
    '{0, 0, 0, 0, 32767, -32768, 0, 0, 0},
    '{1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_sample_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_sample_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state, at its reset values.
  logic [CFG_DATA_BITS-1:0] freq_reg = '0;
  logic [PH_BITS-1:0] phase_reg = '0;
  logic mode_reg = 1'b1;
  longint sine_lut [LUT_SIZE];

  out_sample_t predicted_samples [$];
  int mismatches = 0;
  int quiet = 0;
  int src_gap_pct = 11;
  int snk_stall_pct = 46;

  complex_nco_mixer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sine of quarter-wave entry r: odd Taylor terms on Q30 magnitudes, then scaled to the amplitude.
  function automatic longint quarter_wave(longint unsigned r);
    longint unsigned ang;
    longint unsigned term;
    longint sum;
    longint v;
    ang = (r * 64'd2 * PI_Q30 + (64'd1 << (TAB_BITS - 1))) >> TAB_BITS;
    term = ang;
    sum = longint'(ang);
    for (int k = 3; k <= 17; k += 2) begin
      term = ((term * ang) >> 30) * ang >> 30;
      term = term / longint'(k * (k - 1));
      if (k % 4 == 3) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * AMP_MAX + (longint'(1) << 29)) >>> 30;
    return (v > AMP_MAX) ? longint'(AMP_MAX) : v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] round_clip(longint p);
    longint v;
    v = (p + (longint'(1) << (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
    if (v > AMP_MAX) begin
      v = AMP_MAX;
    end else if (v < -AMP_MAX - 1) begin
      v = -AMP_MAX - 1;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Advances the phase unless the frequency word is zero, and returns the mixer output for one accepted sample.
  function automatic out_sample_t mix_sample(in_sample_t smp);
    out_sample_t res;
    logic [TAB_BITS-1:0] sin_addr;
    logic [TAB_BITS-1:0] cos_addr;
    longint xr;
    longint xi;
    longint c;
    longint s;
    xr = longint'($signed(smp.in_re));
    xi = longint'($signed(smp.in_im));
    if (freq_reg == '0) begin
      res.out_re = smp.in_re;
      res.out_im = smp.in_im;
      return res;
    end
    phase_reg = phase_reg + freq_reg;
    sin_addr = phase_reg[PH_BITS-1 -: TAB_BITS];
    cos_addr = sin_addr + TAB_BITS'(QUARTER);
    s = sine_lut[sin_addr];
    c = sine_lut[cos_addr];
    if (!mode_reg) begin
      res.out_re = c[SAMPLE_BITS-1:0];
      res.out_im = s[SAMPLE_BITS-1:0];
    end else begin
      res.out_re = round_clip(xr * c - xi * s);
      res.out_im = round_clip(xr * s + xi * c);
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_component();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_BITS'($urandom_range(0, 15)) - 16'sd8;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_freq();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return CFG_DATA_BITS'($urandom_range(1, 4096));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_start();
    case ($urandom_range(3))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // with in_valid still high.
  task automatic push_sample(input in_sample_t smp, input bit known, input out_sample_t typed);
    out_sample_t res;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = mix_sample(smp);
    predicted_samples.push_back(known ? typed : res);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need one assignment per edge.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FREQ_WORD: freq_reg = val;
      REG_START_PHASE: phase_reg = val[CFG_DATA_BITS-1 -: PH_BITS];
      REG_GEN_MODE: mode_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic setup_nco(input logic [CFG_DATA_BITS-1:0] freq,
                           input logic [CFG_DATA_BITS-1:0] start,
                           input logic [CFG_DATA_BITS-1:0] mode_word,
                           input bit load_start);
    in_valid <= 1'b0;
    while (predicted_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_FREQ_WORD, freq);
    if (load_start) begin
      write_reg(REG_START_PHASE, start);
    end
    write_reg(REG_GEN_MODE, mode_word);
    write_reg(CFG_IDX_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  always @(posedge clk) begin
    out_sample_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_samples.size() == 0) begin
        $error("unexpected output sample re=%0d im=%0d", out_data.out_re, out_data.out_im);
        mismatches++;
      end else begin
        exp = predicted_samples.pop_front();
        if (out_data.out_re !== exp.out_re) begin
          $error("out_re: expected %0d, got %0d", exp.out_re, out_data.out_re);
          mismatches++;
        end
        if (out_data.out_im !== exp.out_im) begin
          $error("out_im: expected %0d, got %0d", exp.out_im, out_data.out_im);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[complex_nco_mixer] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int quad;
    int offs;
    longint wave;
    in_sample_t smp;
    out_sample_t typed;
    vector_t vec;
    int segs;

    for (int a = 0; a < LUT_SIZE; a++) begin
      quad = a / QUARTER;
      offs = a % QUARTER;
      wave = (quad % 2 == 1) ? quarter_wave(QUARTER - offs) : quarter_wave(offs);
      sine_lut[a] = (quad >= 2) ? -wave : wave;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      vec = directed_vectors[i];
      if (vec.cfg) begin
        setup_nco(vec.freq, vec.start, vec.mode_word, 1'b1);
      end
      smp.in_re = vec.re;
      smp.in_im = vec.im;
      typed.out_re = vec.exp_re;
      typed.out_im = vec.exp_im;
      push_sample(smp, vec.known, typed);
    end

    // Each segment gets new settings; the idle pattern changes every third of the run.
    segs = RAND_ITEMS / SEG_LEN;
    for (int g = 0; g < segs; g++) begin
      case (g * 3 / segs)
        0: begin
          src_gap_pct = 11;
          snk_stall_pct = 46;
        end
        1: begin
          src_gap_pct = 46;
          snk_stall_pct = 11;
        end
        default: begin
          src_gap_pct = 0;
          snk_stall_pct = 0;
        end
      endcase
      setup_nco(rand_freq(), rand_start(), $urandom, 1'($urandom));
      for (int n = 0; n < SEG_LEN; n++) begin
        smp.in_re = rand_component();
        smp.in_im = rand_component();
        push_sample(smp, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (predicted_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && predicted_samples.size() == 0) begin
      $display("[complex_nco_mixer] OK");
    end else begin
      $display("[complex_nco_mixer] ERROR");
    end
    $finish;
  end

endmodule
